// ===== hdl/assert_macros.svh =====
// assertion macros used by the framer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define SDBF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SDBF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/sdbf_pkg.sv =====
// types and constants of the surveillance data block framer
package sdbf_pkg;

    localparam int HEADER_BYTES    = 3;
    localparam int MIN_BLOCK_BYTES = 4;
    localparam int CFG_REGS        = 4;
    localparam int CFG_INDEX_W     = 8;

    localparam logic [2:0] ROLE_CATEGORY = 3'd0;
    localparam logic [2:0] ROLE_LEN_HI   = 3'd1;
    localparam logic [2:0] ROLE_LEN_LO   = 3'd2;
    localparam logic [2:0] ROLE_BODY     = 3'd3;
    localparam logic [2:0] ROLE_TRAIL    = 3'd4;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ACCEPT    = 3'd1;
    localparam logic [2:0] EV_MALFORMED = 3'd2;
    localparam logic [2:0] EV_DISABLED  = 3'd3;
    localparam logic [2:0] EV_TRAIL     = 3'd4;

    typedef logic [CFG_REGS-1:0][63:0] mask_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_packet;
        logic [15:0] packet_length;
    } item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  byte_role;
        logic [7:0]  block_category;
        logic [15:0] block_offset;
        logic        category_enabled;
        logic [2:0]  event_code;
        logic        end_of_block;
        logic        end_of_packet;
    } result_t;

endpackage

// ===== hdl/sdbf_cfg_regs.sv =====
// category enable mask registers
module sdbf_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sdbf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                       cfg_data,
    output sdbf_pkg::mask_t                   mask
);

    sdbf_pkg::mask_t mask_reg;
    logic            hit;

    assign cfg_ready = 1'b1;
    assign hit = cfg_index < sdbf_pkg::CFG_INDEX_W'(sdbf_pkg::CFG_REGS);
    assign mask = mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cfg_valid && hit) begin
            mask_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

endmodule

// ===== hdl/sdbf_in_reg.sv =====
// input holding register
module sdbf_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sdbf_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output sdbf_pkg::item_t item
);

    logic            valid_reg;
    sdbf_pkg::item_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hdl/sdbf_parser.sv =====
// block parsing state and per-byte tagging
module sdbf_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  sdbf_pkg::item_t   item,
    input  sdbf_pkg::mask_t   mask,
    output sdbf_pkg::result_t result
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;

    logic [15:0] pkt_left_reg, pkt_left_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  cat_reg, cat_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] blk_len_reg, blk_len_next;
    logic [15:0] blk_pos_reg, blk_pos_next;
    logic [15:0] blk_start_reg, blk_start_next;

    logic [15:0] left;
    logic [2:0]  ph;
    logic [15:0] len_word;
    logic [15:0] pos_inc;
    logic [7:0]  cat_sel;
    logic        en_bit;

    assign left     = item.first_of_packet ? item.packet_length : pkt_left_reg;
    assign ph       = item.first_of_packet ? PH_HEADER : phase_reg;
    assign len_word = {len_hi_reg, item.data_byte};
    assign pos_inc  = blk_pos_reg + 16'd1;
    // category of the block this byte belongs to
    assign cat_sel  = (ph == PH_HEADER) ? item.data_byte : cat_reg;
    assign en_bit   = mask[cat_sel[7:6]][cat_sel[5:0]];

    always_comb begin
        pkt_left_next  = left;
        phase_next     = ph;
        cat_next       = cat_reg;
        len_hi_next    = len_hi_reg;
        blk_len_next   = blk_len_reg;
        blk_pos_next   = blk_pos_reg;
        blk_start_next = blk_start_reg;

        result                  = '0;
        result.byte_out         = item.data_byte;
        result.byte_role        = sdbf_pkg::ROLE_TRAIL;
        result.event_code       = sdbf_pkg::EV_NONE;

        if (left != 16'd0) begin
            case (ph)
                PH_HEADER: begin
                    if (left < 16'(sdbf_pkg::MIN_BLOCK_BYTES)) begin
                        result.event_code = sdbf_pkg::EV_TRAIL;
                        phase_next = PH_SKIP;
                    end else begin
                        cat_next = item.data_byte;
                        blk_start_next = left;
                        result.byte_role = sdbf_pkg::ROLE_CATEGORY;
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    len_hi_next = item.data_byte;
                    result.byte_role = sdbf_pkg::ROLE_LEN_HI;
                    result.block_offset = 16'd1;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    blk_len_next = len_word;
                    result.byte_role = sdbf_pkg::ROLE_LEN_LO;
                    result.block_offset = 16'd2;
                    if (len_word < 16'(sdbf_pkg::HEADER_BYTES) || len_word > blk_start_reg) begin
                        result.event_code = sdbf_pkg::EV_MALFORMED;
                        phase_next = PH_SKIP;
                    end else begin
                        result.event_code = en_bit ? sdbf_pkg::EV_ACCEPT
                                                   : sdbf_pkg::EV_DISABLED;
                        if (len_word == 16'(sdbf_pkg::HEADER_BYTES)) begin
                            result.end_of_block = 1'b1;
                            phase_next = PH_HEADER;
                        end else begin
                            blk_pos_next = 16'(sdbf_pkg::HEADER_BYTES);
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    result.byte_role = sdbf_pkg::ROLE_BODY;
                    result.block_offset = blk_pos_reg;
                    blk_pos_next = pos_inc;
                    if (pos_inc >= blk_len_reg) begin
                        result.end_of_block = 1'b1;
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    phase_next = PH_SKIP;
                end
            endcase
            if (result.byte_role != sdbf_pkg::ROLE_TRAIL) begin
                result.block_category   = cat_next;
                result.category_enabled = en_bit;
            end
            pkt_left_next = left - 16'd1;
            if (pkt_left_next == 16'd0) begin
                result.end_of_packet = 1'b1;
                phase_next = PH_HEADER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_left_reg  <= '0;
            phase_reg     <= PH_HEADER;
            cat_reg       <= '0;
            len_hi_reg    <= '0;
            blk_len_reg   <= '0;
            blk_pos_reg   <= '0;
            blk_start_reg <= '0;
        end else if (step) begin
            pkt_left_reg  <= pkt_left_next;
            phase_reg     <= phase_next;
            cat_reg       <= cat_next;
            len_hi_reg    <= len_hi_next;
            blk_len_reg   <= blk_len_next;
            blk_pos_reg   <= blk_pos_next;
            blk_start_reg <= blk_start_next;
        end
    end

endmodule

// ===== hdl/sdbf_out_reg.sv =====
// result register toward the output channel
module sdbf_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  sdbf_pkg::result_t result,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output sdbf_pkg::result_t m_result
);

    logic              valid_reg;
    sdbf_pkg::result_t result_reg;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== hdl/surveillance_data_block_framer_unit.sv =====
// path: a byte is held in the input register, then tagged into the result register
// throughput: one byte per cycle unless the output stalls, set by the single parse step
//   from input register to result register with the parse state updated in that cycle
// reset: synchronous active-low aresetn clears both stage valids, the parse
//   state and the category masks; no clearing pass, usable right after reset
`include "assert_macros.svh"

module surveillance_data_block_framer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_first_of_packet,
    input  logic [15:0]                      s_packet_length,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_byte_out,
    output logic [2:0]                       m_byte_role,
    output logic [7:0]                       m_block_category,
    output logic [15:0]                      m_block_offset,
    output logic                             m_category_enabled,
    output logic [2:0]                       m_event_code,
    output logic                             m_end_of_block,
    output logic                             m_end_of_packet
);

    sdbf_pkg::mask_t   mask;
    sdbf_pkg::item_t   s_item, item;
    sdbf_pkg::result_t result, m_result;
    logic              item_valid, out_free, step;
    logic              trail_ok, eob_ok, event_ok;

    assign s_item.data_byte       = s_data_byte;
    assign s_item.first_of_packet = s_first_of_packet;
    assign s_item.packet_length   = s_packet_length;

    // a held byte moves on when the result register has room
    assign step = item_valid && out_free;

    sdbf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mask      (mask)
    );

    sdbf_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    sdbf_parser u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .mask    (mask),
        .result  (result)
    );

    sdbf_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_byte_out         = m_result.byte_out;
    assign m_byte_role        = m_result.byte_role;
    assign m_block_category   = m_result.block_category;
    assign m_block_offset     = m_result.block_offset;
    assign m_category_enabled = m_result.category_enabled;
    assign m_event_code       = m_result.event_code;
    assign m_end_of_block     = m_result.end_of_block;
    assign m_end_of_packet    = m_result.end_of_packet;

    assign trail_ok = m_byte_role != sdbf_pkg::ROLE_TRAIL
                      || (m_block_category == 8'd0 && m_block_offset == 16'd0
                          && !m_category_enabled);
    assign eob_ok   = !m_end_of_block
                      || m_byte_role == sdbf_pkg::ROLE_LEN_LO
                      || m_byte_role == sdbf_pkg::ROLE_BODY;
    assign event_ok = m_event_code == sdbf_pkg::EV_NONE
                      || (m_byte_role == sdbf_pkg::ROLE_LEN_LO
                          && m_event_code != sdbf_pkg::EV_TRAIL)
                      || (m_byte_role == sdbf_pkg::ROLE_TRAIL
                          && m_event_code == sdbf_pkg::EV_TRAIL);

    `SDBF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")
    `SDBF_ASSERT(a_trail_clean, m_valid |-> trail_ok, "trailing byte carries block fields")
    `SDBF_ASSERT(a_eob_role, m_valid |-> eob_ok, "end of block on a header byte")
    `SDBF_ASSERT(a_event_role, m_valid |-> event_ok, "event on a wrong byte role")

endmodule
